// ===== hdl/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg
// Shared types, constants and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int VALUE_PORT_W = 31;
  localparam int RADIX_W      = 5;
  localparam int DIGIT_W      = 4;
  localparam int CHAR_W       = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

  typedef logic [RADIX_W-1:0] radix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } i2rd_qstat_t;

  function automatic radix_t clamp_radix(input radix_t r);
    radix_t res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) c = CHAR_ZERO + CHAR_W'(d);
    else           c = CHAR_A + CHAR_W'(d - 4'd10);
    return c;
  endfunction

endpackage

// ===== hdl/i2rd_front.sv =====
// ----------------------------------------------------------------------------
// i2rd_front
// Holds the radix register, takes requests and classifies them: masks the
// value to the working width and saturates the radix before queueing.
// ----------------------------------------------------------------------------
module i2rd_front import i2rd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [VALUE_PORT_W-1:0]   in_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  radix_t                    cfg_radix,
  input  i2rd_qstat_t               q_stat,
  output logic                      push,
  output logic [VALUE_BITS+RADIX_W-1:0] push_item
);

  radix_t radix_r;
  radix_t radix_nxt;

  assign cfg_ready = 1'b1;
  assign radix_nxt = (cfg_valid && cfg_ready) ? cfg_radix : radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  assign busy      = q_stat.full;
  assign push      = start && !busy;
  assign push_item = {clamp_radix(radix_r), VALUE_BITS'(in_value)};

endmodule

// ===== hdl/i2rd_queue.sv =====
// ----------------------------------------------------------------------------
// i2rd_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module i2rd_queue import i2rd_pkg::*; #(
  parameter int WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_item,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_item,
  output i2rd_qstat_t      q_stat
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign pop_item     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hdl/i2rd_back.sv =====
// ----------------------------------------------------------------------------
// i2rd_back
// Divides by the radix one digit per pass (reciprocal multiply, then one
// correction step), fills the digit store, then plays it out backwards.
// ----------------------------------------------------------------------------
module i2rd_back import i2rd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2rd_qstat_t                   q_stat,
  input  logic [VALUE_BITS+RADIX_W-1:0] pop_item,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [CHAR_W-1:0]             out_digit_char,
  output logic                          out_last_digit
);

  localparam int VB    = VALUE_BITS;
  localparam int CNT_W = $clog2(VB);
  localparam int EXT_W = VB + RADIX_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VB - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // floor(2^VB / r) for every radix code, saturated like the radix itself
  logic [VB-1:0] recip_tab [32];
  for (genvar k = 0; k < 32; k++) begin : g_recip
    localparam int KK = (k < 2) ? 2 : ((k > 16) ? 16 : k);
    localparam longint unsigned RK = (64'd1 << VB) / KK;
    assign recip_tab[k] = RK[VB-1:0];
  end

  logic [1:0]        state_r, state_nxt;
  logic [VB-1:0]     q_r, q_nxt;
  logic [VB-1:0]     est_r, est_nxt;
  radix_t            r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              dv_r, dv_nxt;
  logic              last_r, last_nxt;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [DIGIT_W-1:0] digit_store [VB];

  logic [2*VB-1:0]   prod;
  logic [EXT_W-1:0]  est_x_r;
  logic [EXT_W-1:0]  rem_w;
  logic [RADIX_W-1:0] rem5;
  logic [RADIX_W-1:0] rem_adj;
  logic [VB-1:0]     q_fix;
  logic              wr_en;

  assign prod    = (2*VB)'(q_r) * (2*VB)'(recip_tab[r_r]);
  assign est_x_r = EXT_W'(est_r) * EXT_W'(r_r);
  assign rem_w   = EXT_W'(q_r) - est_x_r;
  assign rem5    = rem_w[RADIX_W-1:0];

  // estimate is the true quotient or one short of it
  always_comb begin
    if (rem5 >= r_r) begin
      rem_adj = rem5 - r_r;
      q_fix   = est_r + VB'(1);
    end else begin
      rem_adj = rem5;
      q_fix   = est_r;
    end
  end

  assign pop   = (state_r == S_IDLE) && !q_stat.empty;
  assign wr_en = (state_r == S_FIX);

  always_comb begin
    state_nxt  = state_r;
    q_nxt      = q_r;
    est_nxt    = est_r;
    r_nxt      = r_r;
    cnt_nxt    = cnt_r;
    rd_ptr_nxt = rd_ptr_r;
    dv_nxt     = 1'b0;
    last_nxt   = last_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          q_nxt     = pop_item[VB-1:0];
          r_nxt     = pop_item[EXT_W-1:VB];
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        est_nxt   = prod[2*VB-1:VB];
        state_nxt = S_FIX;
      end
      S_FIX: begin
        q_nxt = q_fix;
        if (q_fix == '0 || cnt_r == CNT_LAST) begin
          rd_ptr_nxt = cnt_r;
          state_nxt  = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        dv_nxt   = 1'b1;
        last_nxt = (rd_ptr_r == '0);
        if (rd_ptr_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          rd_ptr_nxt = rd_ptr_r - CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      last_r  <= 1'b0;
      r_r     <= RADIX_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      last_r  <= last_nxt;
      r_r     <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r      <= q_nxt;
    est_r    <= est_nxt;
    rd_ptr_r <= rd_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) digit_store[cnt_r] <= rem_adj[DIGIT_W-1:0];
    rd_data_r <= digit_store[rd_ptr_r];
  end

  assign out_strobe     = dv_r;
  assign out_digit_char = digit_to_ascii(rd_data_r);
  assign out_last_digit = last_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |-> (rem_w < (EXT_W'(r_r) << 1)))
    else $error("division estimate off by more than one");

  a_est_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |-> (est_r <= q_r))
    else $error("quotient estimate exceeds dividend");

  a_radix_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (r_r >= RADIX_MIN && r_r <= RADIX_MAX))
    else $error("working radix out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r && last_r) |=> !dv_r)
    else $error("digit emitted after last digit");

endmodule

// ===== hdl/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a non-negative integer to ASCII digits in radix 2..16, most
// significant digit first, last digit flagged.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  request  | start, busy, in_value                  | start && !busy
//  result   | out_strobe, out_digit_char, out_last_digit | one-cycle strobe
//  config   | cfg_valid, cfg_ready, cfg_radix        | cfg_valid && cfg_ready
//
// In the back end each divide step is a reciprocal multiply, then a
// correction; the digits are then played out of the digit store. A
// two-entry queue takes requests meanwhile.
// Reset is synchronous, active low; radix resets to 10.
// Results cannot be stalled: each digit is on the ports for one cycle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits import i2rd_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VALUE_PORT_W-1:0] in_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  radix_t                  cfg_radix,
  output logic                    out_strobe,
  output logic [CHAR_W-1:0]       out_digit_char,
  output logic                    out_last_digit
);

  localparam int ITEM_W = VALUE_BITS + RADIX_W;

  i2rd_qstat_t       q_stat;
  logic              push;
  logic              pop;
  logic [ITEM_W-1:0] push_item;
  logic [ITEM_W-1:0] pop_item;

  i2rd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  i2rd_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  i2rd_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop_item       (pop_item),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
